// ===== rtl/wwsf_pkg.sv =====
package wwsf_pkg;

  // Input kind codes
  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_PATTERN = 2'd1;
  localparam logic [1:0] KIND_MESSAGE = 2'd2;

  // Glob wildcards
  localparam logic [15:0] SYM_ANY = 16'h003F;  // '?'
  localparam logic [15:0] SYM_RUN = 16'h002A;  // '*'

  // Token that walks down the slot chain, one cell per cycle while the chain advances
  typedef struct packed {
    logic        clr;       // empty the store
    logic        wr;        // store sym in the first free slot
    logic [15:0] sym;       // pattern or message character
    logic        first;     // stored slot opens a pattern
    logic        unmark;    // drop the end mark of the last filled slot
    logic        ch;        // message character step
    logic        fresh;     // character opens a word
    logic        fin;       // word ends after this step
    logic        emit;      // message verdict leaves at the tail
    logic        ovf;       // store overflow flag to report
    logic        prev_old;  // mark of the previous slot before the step
    logic        prev_new;  // mark of the previous slot after the step
    logic        hit;       // some end slot matched the finished word
  } tok_t;

  // Unicode whitespace set used to split patterns and words
  function automatic logic is_blank(input logic [15:0] c);
    logic b;
    b = 1'b0;
    if (c >= 16'h0009 && c <= 16'h000D) b = 1'b1;
    if (c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) b = 1'b1;
    if (c >= 16'h2000 && c <= 16'h200A) b = 1'b1;
    if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F) b = 1'b1;
    if (c == 16'h3000) b = 1'b1;
    return b;
  endfunction

endpackage

// ===== rtl/wwsf_cell.sv =====
module wwsf_cell
  import wwsf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  tok_t tok_in,
  input  logic nxt_valid,
  output logic valid,
  output tok_t tok_out
);

  logic [15:0] sym_r;
  logic        first_r;
  logic        end_r;
  logic        valid_r;
  logic        active_r;
  tok_t        tok_r;

  logic        run;
  logic        in_old;
  logic        in_new;
  logic        old_mark;
  logic        now_mark;
  logic        end_mark;
  tok_t        tok_nxt;

  // Match step for this slot
  always_comb begin
    run      = (sym_r == SYM_RUN);
    in_old   = first_r ? tok_in.fresh : tok_in.prev_old;
    in_new   = first_r ? 1'b0 : tok_in.prev_new;
    old_mark = tok_in.fresh ? (run && in_old) : active_r;
    if (run) begin
      now_mark = old_mark || in_new;
    end else begin
      now_mark = in_old && (sym_r == SYM_ANY || sym_r == tok_in.sym);
    end
    end_mark = tok_in.ch ? now_mark : active_r;
  end

  // Outgoing token
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.wr && !valid_r) begin
      tok_nxt.wr = 1'b0;
    end
    if (valid_r && tok_in.ch) begin
      tok_nxt.prev_old = old_mark;
      tok_nxt.prev_new = now_mark;
    end
    if (valid_r && tok_in.fin && end_r && end_mark) begin
      tok_nxt.hit = 1'b1;
    end
  end

  // Slot contents
  always_ff @(posedge clk) begin
    if (adv && tok_in.wr && !valid_r) begin
      sym_r   <= tok_in.sym;
      first_r <= tok_in.first;
    end
  end

  // Slot control and marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      active_r <= 1'b0;
      end_r    <= 1'b0;
      tok_r    <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      if (tok_in.clr) begin
        valid_r  <= 1'b0;
        active_r <= 1'b0;
      end else if (tok_in.wr && !valid_r) begin
        valid_r  <= 1'b1;
        active_r <= 1'b0;
        end_r    <= 1'b1;
      end else if (valid_r) begin
        if (tok_in.unmark && !nxt_valid) begin
          end_r <= 1'b0;
        end
        if (tok_in.ch) begin
          active_r <= now_mark;
        end
      end
    end
  end

  assign valid   = valid_r;
  assign tok_out = tok_r;

endmodule

// ===== rtl/wwsf_head.sv =====
module wwsf_head
  import wwsf_pkg::*;
#(
  parameter int PATTERN_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        accept,
  input  logic [1:0]  kind,
  input  logic [15:0] symbol,
  input  logic        last,
  output tok_t        tok
);

  localparam int FILL_W = $clog2(PATTERN_SLOTS + 1);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              loading_r, loading_nxt;
  logic              reading_r, reading_nxt;
  logic              ovf_r, ovf_nxt;
  logic              blank;
  logic              full;

  // Decode the transaction into a chain token and update stream state
  always_comb begin
    blank       = is_blank(symbol);
    full        = (fill_r == FILL_W'(PATTERN_SLOTS));
    tok         = '0;
    fill_nxt    = fill_r;
    loading_nxt = loading_r;
    reading_nxt = reading_r;
    ovf_nxt     = ovf_r;
    if (in_valid) begin
      case (kind)
        KIND_CLEAR: begin
          tok.clr     = 1'b1;
          fill_nxt    = '0;
          loading_nxt = 1'b0;
          ovf_nxt     = 1'b0;
        end
        KIND_PATTERN: begin
          if (blank) begin
            loading_nxt = 1'b0;
          end else if (full) begin
            // cut pattern loses its end so it never matches
            tok.unmark  = !ovf_r && loading_r;
            ovf_nxt     = 1'b1;
            loading_nxt = 1'b1;
          end else begin
            tok.wr      = 1'b1;
            tok.sym     = symbol;
            tok.first   = !loading_r;
            tok.unmark  = loading_r && (fill_r != '0);
            fill_nxt    = fill_r + FILL_W'(1);
            loading_nxt = 1'b1;
          end
        end
        KIND_MESSAGE: begin
          tok.emit = last;
          tok.ovf  = ovf_r;
          if (blank) begin
            tok.fin     = reading_r;
            reading_nxt = 1'b0;
          end else begin
            tok.ch      = 1'b1;
            tok.sym     = symbol;
            tok.fresh   = !reading_r;
            tok.fin     = last;
            reading_nxt = !last;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      loading_r <= 1'b0;
      reading_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (accept) begin
      fill_r    <= fill_nxt;
      loading_r <= loading_nxt;
      reading_r <= reading_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

// ===== rtl/wildcard_word_spam_filter_unit.sv =====
// Glob word filter over a stream of 16-bit characters. One transaction is
// taken every clock while the result side is not stalled. Each character
// becomes a token that walks down a chain of PATTERN_SLOTS cells, one cell
// per clock while the chain advances; every cell holds one pattern character
// with its first/end marks and its match mark. The verdict of a message is
// taken from the token that leaves the chain tail and is registered into the
// output. A result held by out_stall freezes the whole chain and raises
// in_stall until it is taken.
module wildcard_word_spam_filter_unit
  import wwsf_pkg::*;
#(
  parameter int PATTERN_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_symbol,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_spam_found,
  output logic        out_patterns_truncated
);

  tok_t                 chain [0:PATTERN_SLOTS];
  logic [PATTERN_SLOTS:0] valid_vec;
  logic                 adv;
  logic                 accept;
  tok_t                 tail;

  logic                 msg_hit_r;
  logic                 out_valid_r;
  logic                 out_spam_r;
  logic                 out_trunc_r;

  // Whole chain moves unless a finished result is held
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  wwsf_head #(
    .PATTERN_SLOTS(PATTERN_SLOTS)
  ) u_head (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .accept  (accept),
    .kind    (in_kind),
    .symbol  (in_symbol),
    .last    (in_last),
    .tok     (chain[0])
  );

  assign valid_vec[PATTERN_SLOTS] = 1'b0;

  // Slot chain; a write still in flight one cell ahead counts as a filled neighbor
  for (genvar i = 0; i < PATTERN_SLOTS; i++) begin : g_cell
    wwsf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .tok_in   (chain[i]),
      .nxt_valid(valid_vec[i+1] || chain[i+1].wr),
      .valid    (valid_vec[i]),
      .tok_out  (chain[i+1])
    );
  end

  assign tail = chain[PATTERN_SLOTS];

  // Message verdict and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        if (tail.emit) begin
          out_valid_r <= 1'b1;
          msg_hit_r   <= 1'b0;
        end else if (tail.hit) begin
          msg_hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail.emit) begin
      out_spam_r  <= msg_hit_r || tail.hit;
      out_trunc_r <= tail.ovf;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_spam_found         = out_spam_r;
  assign out_patterns_truncated = out_trunc_r;

endmodule
